/* hw/rtl/mfp_pkg.sv */
// Package for the motion-capture frame packet parser.
// Holds the record type, record kinds and error codes; no dependencies.
`default_nettype none
package mfp_pkg;

    localparam logic [3:0] KIND_HEADER     = 4'd0;
    localparam logic [3:0] KIND_NAME_CHAR  = 4'd1;
    localparam logic [3:0] KIND_SET_START  = 4'd2;
    localparam logic [3:0] KIND_MARKER     = 4'd3;
    localparam logic [3:0] KIND_UNIDENT    = 4'd4;
    localparam logic [3:0] KIND_POSE       = 4'd5;
    localparam logic [3:0] KIND_ORIENT     = 4'd6;
    localparam logic [3:0] KIND_BODY_MARK  = 4'd7;
    localparam logic [3:0] KIND_BODY_STAT  = 4'd8;
    localparam logic [3:0] KIND_SKELETON   = 4'd9;
    localparam logic [3:0] KIND_LABELED    = 4'd10;
    localparam logic [3:0] KIND_TRAILER    = 4'd11;
    localparam logic [3:0] KIND_TIMESTAMP  = 4'd12;
    localparam logic [3:0] KIND_FRAME_FLAG = 4'd13;
    localparam logic [3:0] KIND_UNKNOWN    = 4'd14;
    localparam logic [3:0] KIND_ERROR      = 4'd15;

    localparam logic [31:0] ERR_MARKER_OVF = 32'd1;
    localparam logic [31:0] ERR_TRUNCATED  = 32'd2;
    localparam logic [31:0] ERR_TRAILING   = 32'd3;
    localparam logic [31:0] ERR_NAME_LONG  = 32'd4;

    localparam logic [15:0] FRAME_MSG_ID = 16'd7;

    localparam logic CFG_MAJOR = 1'b0;
    localparam logic CFG_MINOR = 1'b1;

    typedef struct packed {
        logic [3:0]  record_kind;
        logic [15:0] group_index;
        logic [15:0] item_index;
        logic [31:0] ident;
        logic [31:0] word_x;
        logic [31:0] word_y;
        logic [31:0] word_z;
        logic [31:0] word_w;
        logic [2:0]  flags;
        logic [15:0] consumed_bytes;
        logic        last;
    } record_t;

    function automatic record_t mk_rec(
        input logic [3:0]  kind,
        input logic [15:0] grp,
        input logic [15:0] item,
        input logic [31:0] ident,
        input logic [31:0] x,
        input logic [31:0] y,
        input logic [31:0] z,
        input logic [31:0] w,
        input logic [2:0]  fl
    );
        record_t r;
        r.record_kind    = kind;
        r.group_index    = grp;
        r.item_index     = item;
        r.ident          = ident;
        r.word_x         = x;
        r.word_y         = y;
        r.word_z         = z;
        r.word_w         = w;
        r.flags          = fl;
        r.consumed_bytes = 16'd0;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/mfp_if.sv */
// Channel interfaces of the frame packet parser: packet bytes in, records out.
// Depends on nothing.
`default_nettype none
interface mfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_last;
    modport source (output valid, output data_byte, output packet_last, input ready);
    modport sink (input valid, input data_byte, input packet_last, output ready);
endinterface

interface mfp_rec_if;
    logic                valid;
    logic                ready;
    logic [3:0]          record_kind;
    logic [15:0]         group_index;
    logic [15:0]         item_index;
    logic signed [31:0]  ident;
    logic [31:0]         word_x;
    logic [31:0]         word_y;
    logic [31:0]         word_z;
    logic [31:0]         word_w;
    logic [2:0]          flags;
    logic [15:0]         consumed_bytes;
    logic                last;
    modport source (output valid, output record_kind, output group_index, output item_index,
                    output ident, output word_x, output word_y, output word_z, output word_w,
                    output flags, output consumed_bytes, output last, input ready);
    modport sink (input valid, input record_kind, input group_index, input item_index,
                  input ident, input word_x, input word_y, input word_z, input word_w,
                  input flags, input consumed_bytes, input last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mfp_marker_mem.sv */
// Body-marker position buffer: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module mfp_marker_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [95:0]   wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic [95:0]        rd_data
);
    logic [95:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

/* hw/rtl/mfp_out_fifo.sv */
// Four-entry record queue taking up to two records per cycle, one out.
// Depends on mfp_pkg.
`default_nettype none
module mfp_out_fifo
    import mfp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic [1:0] push_n,
    input  record_t      push_a,
    input  record_t      push_b,
    input  wire logic    pop,
    output logic         has_room,
    output logic         not_empty,
    output record_t      head
);
    record_t     ent [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        do_pop;

    assign not_empty = (cnt_reg != 3'd0);
    assign has_room  = (cnt_reg <= 3'd2);
    assign do_pop    = pop && not_empty;
    assign head      = ent[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, do_pop};
        cnt_next    = cnt_reg + {1'b0, push_n} - {2'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            ent[wr_ptr_reg] <= push_a;
        end
        if (push_n == 2'd2)
        begin
            ent[wr_ptr_reg + 2'd1] <= push_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/mfp_core.sv */
// Parse state machine: assembles little-endian fields and produces records.
// Depends on mfp_pkg; drives the marker buffer in mfp_marker_mem.
`default_nettype none
module mfp_core
    import mfp_pkg::*;
#(
    parameter int MAX_BODY_MARKERS = 64,
    parameter int MAX_NAME_BYTES   = 256,
    parameter int AW               = 6
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    data_byte,
    input  wire logic          packet_last,
    input  wire logic [3:0]    major,
    input  wire logic [3:0]    minor,
    output logic [1:0]         rec_n,
    output record_t            rec_a,
    output record_t            rec_b,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [95:0]        mem_wdata,
    output logic [AW-1:0]      mem_raddr,
    input  wire logic [95:0]   mem_rdata
);
    localparam logic [5:0] PH_MSGID = 6'd0, PH_NBYTES = 6'd1, PH_FRAMENO = 6'd2,
        PH_NSETS = 6'd3, PH_NAME = 6'd4, PH_NMARK = 6'd5, PH_MX = 6'd6, PH_MY = 6'd7,
        PH_MZ = 6'd8, PH_NOTHER = 6'd9, PH_OX = 6'd10, PH_OY = 6'd11, PH_OZ = 6'd12,
        PH_NBODIES = 6'd13, PH_BID = 6'd14, PH_BX = 6'd15, PH_BY = 6'd16, PH_BZ = 6'd17,
        PH_QX = 6'd18, PH_QY = 6'd19, PH_QZ = 6'd20, PH_QW = 6'd21, PH_BNMARK = 6'd22,
        PH_BMX = 6'd23, PH_BMY = 6'd24, PH_BMZ = 6'd25, PH_BMID = 6'd26,
        PH_BMSIZE = 6'd27, PH_BERR = 6'd28, PH_BPARAMS = 6'd29, PH_NSKEL = 6'd30,
        PH_SKID = 6'd31, PH_SKNB = 6'd32, PH_NLAB = 6'd33, PH_LID = 6'd34, PH_LX = 6'd35,
        PH_LY = 6'd36, PH_LZ = 6'd37, PH_LSIZE = 6'd38, PH_LPARAMS = 6'd39,
        PH_NFP = 6'd40, PH_FPID = 6'd41, PH_FPNCH = 6'd42, PH_FPNFR = 6'd43,
        PH_FPVAL = 6'd44, PH_LAT = 6'd45, PH_TC = 6'd46, PH_TCSUB = 6'd47, PH_TS = 6'd48,
        PH_FPARAMS = 6'd49, PH_EOD = 6'd50, PH_DRAIN = 6'd51;

    localparam logic [31:0] MAX_MK   = 32'(MAX_BODY_MARKERS);
    localparam logic [15:0] NAME_LIM = 16'(MAX_NAME_BYTES - 1);

    logic [5:0]  phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic [2:0]  bif_reg, bif_next;
    logic [31:0] held_reg [4];
    logic [31:0] held_next [4];
    logic [31:0] hid_reg, hid_next;
    logic [31:0] outer_reg, outer_next;
    logic [31:0] middle_reg, middle_next;
    logic [31:0] inner_reg, inner_next;
    logic [15:0] grp_reg, grp_next;
    logic [15:0] item_reg, item_next;
    logic [31:0] mki_reg, mki_next;
    logic [31:0] mkt_reg, mkt_next;
    logic        skel_reg, skel_next;
    logic [15:0] bcnt_reg, bcnt_next;

    logic v20, v21, v23, v26, v27, v29;

    function automatic logic v_at(input logic [3:0] mj, input logic [3:0] mn,
                                  input logic [3:0] mi);
        return (mj == 4'd2 && mn >= mi) || mj > 4'd2;
    endfunction

    function automatic logic [31:0] cnt(input logic [31:0] v);
        return v[31] ? 32'd0 : v;
    endfunction

    assign v20 = major >= 4'd2;
    assign v21 = v_at(major, minor, 4'd1);
    assign v23 = v_at(major, minor, 4'd3);
    assign v26 = v_at(major, minor, 4'd6) || major == 4'd0;
    assign v27 = v_at(major, minor, 4'd7);
    assign v29 = v_at(major, minor, 4'd9);

    assign mem_raddr = mki_reg[AW-1:0];

    always_comb
    begin
        logic [63:0] acc_cur;
        logic [3:0]  fsize;
        logic        done;
        logic [31:0] w;
        logic [31:0] n;
        logic        e_valid;
        record_t     e_rec;
        logic        e2_valid;
        record_t     e2_rec;
        logic        f_after_pos, f_after_mk, f_end_body, f_after_bodies;
        logic        f_end_skel, f_after_skel, f_after_lab, f_end_set;
        logic        f_emit_lab, f_end_plate, f_end_chan;
        logic [2:0]  body_fl, lab_fl;

        phase_next  = phase_reg;
        held_next   = held_reg;
        hid_next    = hid_reg;
        outer_next  = outer_reg;
        middle_next = middle_reg;
        inner_next  = inner_reg;
        grp_next    = grp_reg;
        item_next   = item_reg;
        mki_next    = mki_reg;
        mkt_next    = mkt_reg;
        skel_next   = skel_reg;
        bcnt_next   = bcnt_reg;
        acc_next    = acc_reg;
        bif_next    = bif_reg;
        e_valid     = 1'b0;
        e_rec       = '0;
        e2_valid    = 1'b0;
        e2_rec      = '0;
        mem_we      = 1'b0;
        mem_waddr   = mki_reg[AW-1:0];
        mem_wdata   = '0;
        rec_n       = 2'd0;
        rec_a       = '0;
        rec_b       = '0;
        f_after_pos = 1'b0;  f_after_mk = 1'b0;  f_end_body = 1'b0;
        f_after_bodies = 1'b0;  f_end_skel = 1'b0;  f_after_skel = 1'b0;
        f_after_lab = 1'b0;  f_end_set = 1'b0;  f_emit_lab = 1'b0;
        f_end_plate = 1'b0;  f_end_chan = 1'b0;
        body_fl = 3'd0;  lab_fl = 3'd0;
        n = 32'd0;

        acc_cur = acc_reg | (64'(data_byte) << {bif_reg, 3'b000});
        case (phase_reg)
            PH_MSGID, PH_NBYTES, PH_BPARAMS, PH_LPARAMS, PH_FPARAMS: fsize = 4'd2;
            PH_NAME: fsize = 4'd1;
            PH_TS:   fsize = v27 ? 4'd8 : 4'd4;
            default: fsize = 4'd4;
        endcase
        done = ({1'b0, bif_reg} + 4'd1) >= fsize;
        w = acc_cur[31:0];

        if (phase_reg != PH_DRAIN)
        begin
            if (bcnt_reg != 16'hFFFF)
            begin
                bcnt_next = bcnt_reg + 16'd1;
            end
            acc_next = done ? 64'd0 : acc_cur;
            bif_next = done ? 3'd0 : bif_reg + 3'd1;
            if (done)
            begin
                case (phase_reg)
                    PH_MSGID:
                    begin
                        hid_next = {16'd0, w[15:0]};
                        phase_next = PH_NBYTES;
                    end
                    PH_NBYTES:
                    begin
                        if (hid_reg[15:0] != FRAME_MSG_ID)
                        begin
                            e_valid = 1'b1;
                            e_rec = mk_rec(KIND_UNKNOWN, 16'd0, 16'd0,
                                {{16{hid_reg[15]}}, hid_reg[15:0]}, {16'd0, w[15:0]},
                                32'd0, 32'd0, 32'd0, 3'd0);
                            phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            held_next[0] = {16'd0, w[15:0]};
                            phase_next = PH_FRAMENO;
                        end
                    end
                    PH_FRAMENO:
                    begin
                        e_valid = 1'b1;
                        e_rec = mk_rec(KIND_HEADER, 16'd0, 16'd0, w, held_reg[0],
                            32'd0, 32'd0, 32'd0, 3'd0);
                        phase_next = PH_NSETS;
                    end
                    PH_NSETS:
                    begin
                        outer_next = cnt(w);
                        grp_next = 16'd0;
                        if (cnt(w) != 32'd0)
                        begin
                            item_next = 16'd0;
                            phase_next = PH_NAME;
                        end
                        else
                        begin
                            phase_next = PH_NOTHER;
                        end
                    end
                    PH_NAME:
                    begin
                        if (w[7:0] == 8'd0)
                        begin
                            phase_next = PH_NMARK;
                        end
                        else if (item_reg < NAME_LIM)
                        begin
                            e_valid = 1'b1;
                            e_rec = mk_rec(KIND_NAME_CHAR, grp_reg, item_reg, 32'd0,
                                {24'd0, w[7:0]}, 32'd0, 32'd0, 32'd0, 3'd0);
                            item_next = item_reg + 16'd1;
                        end
                        else if (item_reg == NAME_LIM)
                        begin
                            e_valid = 1'b1;
                            e_rec = mk_rec(KIND_ERROR, 16'd0, 16'd0, ERR_NAME_LONG,
                                32'd0, 32'd0, 32'd0, 32'd0, 3'd0);
                            item_next = item_reg + 16'd1;
                        end
                    end
                    PH_NMARK:
                    begin
                        n = cnt(w);
                        e_valid = 1'b1;
                        e_rec = mk_rec(KIND_SET_START, grp_reg, 16'd0, n,
                            32'd0, 32'd0, 32'd0, 32'd0, 3'd0);
                        inner_next = n;
                        item_next = 16'd0;
                        if (n != 32'd0)
                        begin
                            phase_next = PH_MX;
                        end
                        else
                        begin
                            f_end_set = 1'b1;
                        end
                    end
                    PH_MX, PH_OX, PH_BX, PH_QX, PH_BMX, PH_LX, PH_LAT:
                    begin
                        held_next[0] = w;
                        phase_next = phase_reg + 6'd1;
                    end
                    PH_MY, PH_OY, PH_BY, PH_QY, PH_BMY, PH_LY, PH_TC:
                    begin
                        held_next[1] = w;
                        phase_next = phase_reg + 6'd1;
                    end
                    PH_QZ, PH_LZ, PH_TCSUB:
                    begin
                        held_next[2] = w;
                        phase_next = phase_reg + 6'd1;
                    end
                    PH_MZ:
                    begin
                        e_valid = 1'b1;
                        e_rec = mk_rec(KIND_MARKER, grp_reg, item_reg, 32'd0, held_reg[0],
                            held_reg[1], w, 32'd0, 3'd0);
                        item_next = item_reg + 16'd1;
                        inner_next = inner_reg - 32'd1;
                        if (inner_next != 32'd0)
                        begin
                            phase_next = PH_MX;
                        end
                        else
                        begin
                            f_end_set = 1'b1;
                        end
                    end
                    PH_NOTHER:
                    begin
                        outer_next = cnt(w);
                        item_next = 16'd0;
                        skel_next = 1'b0;
                        phase_next = (cnt(w) != 32'd0) ? PH_OX : PH_NBODIES;
                    end
                    PH_OZ:
                    begin
                        e_valid = 1'b1;
                        e_rec = mk_rec(KIND_UNIDENT, 16'd0, item_reg, 32'd0, held_reg[0],
                            held_reg[1], w, 32'd0, 3'd0);
                        item_next = item_reg + 16'd1;
                        outer_next = outer_reg - 32'd1;
                        phase_next = (outer_next != 32'd0) ? PH_OX : PH_NBODIES;
                    end
                    PH_NBODIES:
                    begin
                        middle_next = cnt(w);
                        grp_next = 16'd0;
                        item_next = 16'd0;
                        if (cnt(w) != 32'd0)
                        begin
                            phase_next = PH_BID;
                        end
                        else
                        begin
                            f_after_bodies = 1'b1;
                        end
                    end
                    PH_BID:
                    begin
                        hid_next = w;
                        phase_next = PH_BX;
                    end
                    PH_BZ:
                    begin
                        e_valid = 1'b1;
                        e_rec = mk_rec(KIND_POSE, grp_reg, item_reg, hid_reg, held_reg[0],
                            held_reg[1], w, 32'd0, 3'd0);
                        phase_next = PH_QX;
                    end
                    PH_QW:
                    begin
                        e_valid = 1'b1;
                        e_rec = mk_rec(KIND_ORIENT, grp_reg, item_reg, hid_reg, held_reg[0],
                            held_reg[1], held_reg[2], w, 3'd0);
                        phase_next = PH_BNMARK;
                    end
                    PH_BNMARK:
                    begin
                        n = cnt(w);
                        mkt_next = n;
                        inner_next = n;
                        mki_next = 32'd0;
                        if (v20 && n > MAX_MK)
                        begin
                            e_valid = 1'b1;
                            e_rec = mk_rec(KIND_ERROR, 16'd0, 16'd0, ERR_MARKER_OVF,
                                32'd0, 32'd0, 32'd0, 32'd0, 3'd0);
                        end
                        if (n != 32'd0)
                        begin
                            phase_next = PH_BMX;
                        end
                        else
                        begin
                            f_after_pos = 1'b1;
                        end
                    end
                    PH_BMZ:
                    begin
                        if (v20)
                        begin
                            mem_we = mki_reg < MAX_MK;
                            mem_wdata = {w, held_reg[1], held_reg[0]};
                        end
                        else
                        begin
                            e_valid = 1'b1;
                            e_rec = mk_rec(KIND_BODY_MARK, grp_reg, mki_reg[15:0], hid_reg,
                                held_reg[0], held_reg[1], w, 32'd0, 3'd0);
                        end
                        mki_next = mki_reg + 32'd1;
                        inner_next = inner_reg - 32'd1;
                        if (inner_next != 32'd0)
                        begin
                            phase_next = PH_BMX;
                        end
                        else
                        begin
                            f_after_pos = 1'b1;
                        end
                    end
                    PH_BMID:
                    begin
                        inner_next = inner_reg - 32'd1;
                        if (inner_next == 32'd0)
                        begin
                            inner_next = mkt_reg;
                            mki_next = 32'd0;
                            phase_next = PH_BMSIZE;
                        end
                    end
                    PH_BMSIZE:
                    begin
                        e_valid = 1'b1;
                        if (mki_reg < MAX_MK)
                        begin
                            e_rec = mk_rec(KIND_BODY_MARK, grp_reg, mki_reg[15:0], hid_reg,
                                mem_rdata[31:0], mem_rdata[63:32], mem_rdata[95:64], w, 3'd0);
                        end
                        else
                        begin
                            e_rec = mk_rec(KIND_BODY_MARK, grp_reg, mki_reg[15:0], hid_reg,
                                32'd0, 32'd0, 32'd0, w, 3'd0);
                        end
                        mki_next = mki_reg + 32'd1;
                        inner_next = inner_reg - 32'd1;
                        if (inner_next == 32'd0)
                        begin
                            f_after_mk = 1'b1;
                        end
                    end
                    PH_BERR:
                    begin
                        held_next[3] = w;
                        if (v26)
                        begin
                            phase_next = PH_BPARAMS;
                        end
                        else
                        begin
                            f_end_body = 1'b1;
                        end
                    end
                    PH_BPARAMS:
                    begin
                        f_end_body = 1'b1;
                        body_fl = {2'b00, w[0]};
                    end
                    PH_NSKEL:
                    begin
                        outer_next = cnt(w);
                        grp_next = 16'd0;
                        skel_next = 1'b1;
                        if (cnt(w) != 32'd0)
                        begin
                            phase_next = PH_SKID;
                        end
                        else
                        begin
                            f_after_skel = 1'b1;
                        end
                    end
                    PH_SKID:
                    begin
                        held_next[0] = w;
                        phase_next = PH_SKNB;
                    end
                    PH_SKNB:
                    begin
                        n = cnt(w);
                        e_valid = 1'b1;
                        e_rec = mk_rec(KIND_SKELETON, grp_reg, 16'd0, held_reg[0], n,
                            32'd0, 32'd0, 32'd0, 3'd0);
                        middle_next = n;
                        item_next = 16'd0;
                        if (n != 32'd0)
                        begin
                            phase_next = PH_BID;
                        end
                        else
                        begin
                            f_end_skel = 1'b1;
                        end
                    end
                    PH_NLAB:
                    begin
                        outer_next = cnt(w);
                        item_next = 16'd0;
                        if (cnt(w) != 32'd0)
                        begin
                            phase_next = PH_LID;
                        end
                        else
                        begin
                            f_after_lab = 1'b1;
                        end
                    end
                    PH_LID:
                    begin
                        hid_next = w;
                        phase_next = PH_LX;
                    end
                    PH_LSIZE:
                    begin
                        held_next[3] = w;
                        if (v26)
                        begin
                            phase_next = PH_LPARAMS;
                        end
                        else
                        begin
                            f_emit_lab = 1'b1;
                        end
                    end
                    PH_LPARAMS:
                    begin
                        f_emit_lab = 1'b1;
                        lab_fl = w[2:0];
                    end
                    PH_NFP:
                    begin
                        outer_next = cnt(w);
                        phase_next = (cnt(w) != 32'd0) ? PH_FPID : PH_LAT;
                    end
                    PH_FPID:
                    begin
                        phase_next = PH_FPNCH;
                    end
                    PH_FPNCH:
                    begin
                        middle_next = cnt(w);
                        if (cnt(w) != 32'd0)
                        begin
                            phase_next = PH_FPNFR;
                        end
                        else
                        begin
                            f_end_plate = 1'b1;
                        end
                    end
                    PH_FPNFR:
                    begin
                        inner_next = cnt(w);
                        if (cnt(w) != 32'd0)
                        begin
                            phase_next = PH_FPVAL;
                        end
                        else
                        begin
                            f_end_chan = 1'b1;
                        end
                    end
                    PH_FPVAL:
                    begin
                        inner_next = inner_reg - 32'd1;
                        if (inner_next == 32'd0)
                        begin
                            f_end_chan = 1'b1;
                        end
                    end
                    PH_TS:
                    begin
                        e_valid = 1'b1;
                        if (v27)
                        begin
                            e_rec = mk_rec(KIND_TIMESTAMP, 16'd0, 16'd0, 32'd0, w,
                                acc_cur[63:32], 32'd0, 32'd0, 3'd1);
                        end
                        else
                        begin
                            e_rec = mk_rec(KIND_TIMESTAMP, 16'd0, 16'd0, 32'd0, w,
                                32'd0, 32'd0, 32'd0, 3'd0);
                        end
                        phase_next = PH_FPARAMS;
                    end
                    PH_FPARAMS:
                    begin
                        e_valid = 1'b1;
                        e_rec = mk_rec(KIND_FRAME_FLAG, 16'd0, 16'd0, 32'd0, 32'd0,
                            32'd0, 32'd0, 32'd0, {1'b0, w[1:0]});
                        phase_next = PH_EOD;
                    end
                    PH_EOD:
                    begin
                        e_valid = 1'b1;
                        e_rec = mk_rec(KIND_TRAILER, 16'd0, 16'd0, w, held_reg[0],
                            held_reg[1], held_reg[2], 32'd0, 3'd0);
                        phase_next = PH_DRAIN;
                    end
                    default:
                    begin
                        phase_next = PH_DRAIN;
                    end
                endcase

                if (f_end_set)
                begin
                    outer_next = outer_next - 32'd1;
                    grp_next = grp_next + 16'd1;
                    if (outer_next != 32'd0)
                    begin
                        item_next = 16'd0;
                        phase_next = PH_NAME;
                    end
                    else
                    begin
                        phase_next = PH_NOTHER;
                    end
                end
                if (f_after_pos)
                begin
                    if (v20 && mkt_next != 32'd0)
                    begin
                        inner_next = mkt_next;
                        mki_next = 32'd0;
                        phase_next = PH_BMID;
                    end
                    else
                    begin
                        f_after_mk = 1'b1;
                    end
                end
                if (f_after_mk)
                begin
                    held_next[3] = 32'd0;
                    if (v20)
                    begin
                        phase_next = PH_BERR;
                    end
                    else if (v26)
                    begin
                        phase_next = PH_BPARAMS;
                    end
                    else
                    begin
                        f_end_body = 1'b1;
                    end
                end
                if (f_end_body)
                begin
                    if (e_valid)
                    begin
                        e2_valid = 1'b1;
                        e2_rec = mk_rec(KIND_BODY_STAT, grp_next, item_next, hid_next, 32'd0,
                            32'd0, 32'd0, held_next[3], body_fl);
                    end
                    else
                    begin
                        e_valid = 1'b1;
                        e_rec = mk_rec(KIND_BODY_STAT, grp_next, item_next, hid_next, 32'd0,
                            32'd0, 32'd0, held_next[3], body_fl);
                    end
                    item_next = item_next + 16'd1;
                    middle_next = middle_next - 32'd1;
                    if (middle_next != 32'd0)
                    begin
                        phase_next = PH_BID;
                    end
                    else
                    begin
                        f_after_bodies = 1'b1;
                    end
                end
                if (f_after_bodies)
                begin
                    if (skel_next)
                    begin
                        f_end_skel = 1'b1;
                    end
                    else if (v21)
                    begin
                        phase_next = PH_NSKEL;
                    end
                    else
                    begin
                        f_after_skel = 1'b1;
                    end
                end
                if (f_end_skel)
                begin
                    outer_next = outer_next - 32'd1;
                    grp_next = grp_next + 16'd1;
                    if (outer_next != 32'd0)
                    begin
                        phase_next = PH_SKID;
                    end
                    else
                    begin
                        f_after_skel = 1'b1;
                    end
                end
                if (f_after_skel)
                begin
                    if (v23)
                    begin
                        phase_next = PH_NLAB;
                    end
                    else
                    begin
                        f_after_lab = 1'b1;
                    end
                end
                if (f_emit_lab)
                begin
                    e_valid = 1'b1;
                    e_rec = mk_rec(KIND_LABELED, 16'd0, item_next, hid_next, held_next[0],
                        held_next[1], held_next[2], held_next[3], lab_fl);
                    item_next = item_next + 16'd1;
                    outer_next = outer_next - 32'd1;
                    if (outer_next != 32'd0)
                    begin
                        phase_next = PH_LID;
                    end
                    else
                    begin
                        f_after_lab = 1'b1;
                    end
                end
                if (f_after_lab)
                begin
                    phase_next = v29 ? PH_NFP : PH_LAT;
                end
                if (f_end_chan)
                begin
                    middle_next = middle_next - 32'd1;
                    if (middle_next != 32'd0)
                    begin
                        phase_next = PH_FPNFR;
                    end
                    else
                    begin
                        f_end_plate = 1'b1;
                    end
                end
                if (f_end_plate)
                begin
                    outer_next = outer_next - 32'd1;
                    phase_next = (outer_next != 32'd0) ? PH_FPID : PH_LAT;
                end
            end

            if (e_valid)
            begin
                rec_a = e_rec;
                rec_n = 2'd1;
            end
            if (e2_valid)
            begin
                rec_b = e2_rec;
                rec_n = 2'd2;
            end
            if (packet_last && phase_next != PH_DRAIN)
            begin
                if (e_valid)
                begin
                    rec_b = mk_rec(KIND_ERROR, 16'd0, 16'd0, ERR_TRUNCATED,
                        32'd0, 32'd0, 32'd0, 32'd0, 3'd0);
                    rec_n = 2'd2;
                end
                else
                begin
                    rec_a = mk_rec(KIND_ERROR, 16'd0, 16'd0, ERR_TRUNCATED,
                        32'd0, 32'd0, 32'd0, 32'd0, 3'd0);
                    rec_n = 2'd1;
                end
            end
        end
        else if (packet_last)
        begin
            rec_a = mk_rec(KIND_ERROR, 16'd0, 16'd0, ERR_TRAILING,
                32'd0, 32'd0, 32'd0, 32'd0, 3'd0);
            rec_n = 2'd1;
        end

        rec_a.consumed_bytes = bcnt_next;
        rec_b.consumed_bytes = bcnt_next;
        rec_a.last = packet_last && rec_n == 2'd1;
        rec_b.last = packet_last;
        mem_we = mem_we && step;

        if (packet_last)
        begin
            phase_next  = PH_MSGID;
            acc_next    = 64'd0;
            bif_next    = 3'd0;
            held_next   = '{default: 32'd0};
            hid_next    = 32'd0;
            outer_next  = 32'd0;
            middle_next = 32'd0;
            inner_next  = 32'd0;
            grp_next    = 16'd0;
            item_next   = 16'd0;
            mki_next    = 32'd0;
            mkt_next    = 32'd0;
            skel_next   = 1'b0;
            bcnt_next   = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MSGID;
            acc_reg    <= 64'd0;
            bif_reg    <= 3'd0;
            held_reg   <= '{default: 32'd0};
            hid_reg    <= 32'd0;
            outer_reg  <= 32'd0;
            middle_reg <= 32'd0;
            inner_reg  <= 32'd0;
            grp_reg    <= 16'd0;
            item_reg   <= 16'd0;
            mki_reg    <= 32'd0;
            mkt_reg    <= 32'd0;
            skel_reg   <= 1'b0;
            bcnt_reg   <= 16'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            bif_reg    <= bif_next;
            held_reg   <= held_next;
            hid_reg    <= hid_next;
            outer_reg  <= outer_next;
            middle_reg <= middle_next;
            inner_reg  <= inner_next;
            grp_reg    <= grp_next;
            item_reg   <= item_next;
            mki_reg    <= mki_next;
            mkt_reg    <= mkt_next;
            skel_reg   <= skel_next;
            bcnt_reg   <= bcnt_next;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/mocap_frame_packet_parser.sv */
// A byte is registered, parsed from that register, and its records are written into a
// four-entry queue that hands them out one per cycle while the receiver is ready.
// Throughput: one byte per cycle while records are taken; the queue takes the
// parse result only when it has room for two records.
// Reset clears all parse state, the queue and the version registers to zero;
// the marker position buffer is not cleared.
`default_nettype none
module mocap_frame_packet_parser
    import mfp_pkg::*;
#(
    parameter int MAX_BODY_MARKERS = 64,
    parameter int MAX_NAME_BYTES   = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    mfp_byte_if.sink        pkt,
    mfp_rec_if.source       rec,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [3:0] cfg_data
);
    localparam int AW = (MAX_BODY_MARKERS > 1) ? $clog2(MAX_BODY_MARKERS) : 1;

    logic        s_valid_reg;
    logic [7:0]  s_byte_reg;
    logic        s_last_reg;
    logic [3:0]  major_reg, minor_reg;
    logic        step, has_room, not_empty;
    logic [1:0]  rec_n;
    record_t     rec_a, rec_b, head;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [95:0] mem_wdata, mem_rdata;

    assign step      = s_valid_reg && has_room;
    assign pkt.ready = !s_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            major_reg   <= 4'd0;
            minor_reg   <= 4'd0;
        end
        else
        begin
            if (pkt.ready)
            begin
                s_valid_reg <= pkt.valid;
            end
            if (cfg_we && cfg_index == CFG_MAJOR)
            begin
                major_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_MINOR)
            begin
                minor_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt.ready && pkt.valid)
        begin
            s_byte_reg <= pkt.data_byte;
            s_last_reg <= pkt.packet_last;
        end
    end

    mfp_core #(
        .MAX_BODY_MARKERS (MAX_BODY_MARKERS),
        .MAX_NAME_BYTES   (MAX_NAME_BYTES),
        .AW               (AW)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (s_byte_reg),
        .packet_last (s_last_reg),
        .major       (major_reg),
        .minor       (minor_reg),
        .rec_n       (rec_n),
        .rec_a       (rec_a),
        .rec_b       (rec_b),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    mfp_marker_mem #(
        .DEPTH (MAX_BODY_MARKERS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    mfp_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (step ? rec_n : 2'd0),
        .push_a    (rec_a),
        .push_b    (rec_b),
        .pop       (rec.ready),
        .has_room  (has_room),
        .not_empty (not_empty),
        .head      (head)
    );

    assign rec.valid          = not_empty;
    assign rec.record_kind    = head.record_kind;
    assign rec.group_index    = head.group_index;
    assign rec.item_index     = head.item_index;
    assign rec.ident          = head.ident;
    assign rec.word_x         = head.word_x;
    assign rec.word_y         = head.word_y;
    assign rec.word_z         = head.word_z;
    assign rec.word_w         = head.word_w;
    assign rec.flags          = head.flags;
    assign rec.consumed_bytes = head.consumed_bytes;
    assign rec.last           = head.last;
endmodule
`default_nettype wire

/* tb/mocap_frame_packet_parser_test.sv */
// Testbench for the motion-capture frame packet parser: drives packet bytes, predicts
// every record with a cycle-free model of the parser and checks the records in order.
// Depends on mfp_pkg, mfp_byte_if, mfp_rec_if and mocap_frame_packet_parser.
`default_nettype none
module mocap_frame_packet_parser_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mfp_pkg::*;

    localparam int BODY_MARKER_SLOTS = 64;
    localparam int NAME_LIMIT = 256;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef enum int {
        S_MSGID, S_NBYTES, S_FRAMENO, S_NSETS, S_NAME, S_NMARK, S_MX, S_MY, S_MZ,
        S_NOTHER, S_OX, S_OY, S_OZ, S_NBODIES, S_BID, S_BX, S_BY, S_BZ, S_QX, S_QY,
        S_QZ, S_QW, S_BNMARK, S_BMX, S_BMY, S_BMZ, S_BMID, S_BMSIZE, S_BERR,
        S_BPARAMS, S_NSKEL, S_SKID, S_SKNB, S_NLAB, S_LID, S_LX, S_LY, S_LZ, S_LSIZE,
        S_LPARAMS, S_NFP, S_FPID, S_FPNCH, S_FPNFR, S_FPVAL, S_LAT, S_TC, S_TCSUB,
        S_TS, S_FPARAMS, S_EOD, S_DRAIN
    } parse_state_e;

    class record_scoreboard;
        record_t pending[$];
        record_t step_out[$];
        int errors;
        logic [3:0] major, minor;
        parse_state_e state;
        logic [63:0] acc;
        int unsigned nin;
        logic [31:0] held[4];
        logic [31:0] held_id, outer, middle, inner, mark_idx, mark_tot;
        logic [15:0] grp, itm, bcount;
        bit in_skel;
        logic [31:0] mpos[BODY_MARKER_SLOTS][3];

        function new();
            errors = 0;
            major = 0;
            minor = 0;
            restart();
        endfunction

        function void restart();
            state = S_MSGID;
            acc = 0;
            nin = 0;
            foreach (held[i]) held[i] = 0;
            held_id = 0; outer = 0; middle = 0; inner = 0;
            grp = 0; itm = 0; mark_idx = 0; mark_tot = 0;
            in_skel = 0; bcount = 0;
        endfunction

        function bit at_least(int unsigned mi);
            return (major == 2 && minor >= mi) || major > 2;
        endfunction
        function bit v20(); return major >= 2; endfunction
        function bit v26(); return at_least(6) || major == 0; endfunction
        function bit v21(); return (major == 2 && minor > 0) || major > 2; endfunction
        function logic [31:0] count_of(logic [31:0] c);
            return c[31] ? 32'd0 : c;
        endfunction

        function int unsigned width_of();
            case (state)
                S_MSGID, S_NBYTES, S_BPARAMS, S_LPARAMS, S_FPARAMS: return 2;
                S_NAME: return 1;
                S_TS: return at_least(7) ? 8 : 4;
                default: return 4;
            endcase
        endfunction

        function void emit(logic [3:0] k, logic [15:0] g, logic [15:0] it, logic [31:0] id,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w,
                           logic [2:0] fl);
            record_t r;
            if (step_out.size() >= 2) return;
            r.record_kind = k; r.group_index = g; r.item_index = it; r.ident = id;
            r.word_x = x; r.word_y = y; r.word_z = z; r.word_w = w; r.flags = fl;
            r.consumed_bytes = 0; r.last = 0;
            step_out.push_back(r);
        endfunction

        function void after_labeled(); state = at_least(9) ? S_NFP : S_LAT; endfunction
        function void after_skeletons();
            if (at_least(3)) state = S_NLAB; else after_labeled();
        endfunction
        function void end_skeleton();
            outer--; grp++;
            if (outer != 0) state = S_SKID; else after_skeletons();
        endfunction
        function void after_bodies();
            if (in_skel) end_skeleton();
            else if (v21()) state = S_NSKEL;
            else after_skeletons();
        endfunction
        function void end_body(logic [2:0] fl);
            emit(KIND_BODY_STAT, grp, itm, held_id, 0, 0, 0, held[3], fl);
            itm++; middle--;
            if (middle != 0) state = S_BID; else after_bodies();
        endfunction
        function void after_markers();
            held[3] = 0;
            if (v20()) state = S_BERR;
            else if (v26()) state = S_BPARAMS;
            else end_body(0);
        endfunction
        function void after_positions();
            if (v20() && mark_tot != 0)
            begin
                inner = mark_tot; mark_idx = 0; state = S_BMID;
            end
            else after_markers();
        endfunction
        function void end_set();
            outer--; grp++;
            if (outer != 0)
            begin
                itm = 0; state = S_NAME;
            end
            else state = S_NOTHER;
        endfunction
        function void end_plate();
            outer--; state = (outer != 0) ? S_FPID : S_LAT;
        endfunction
        function void end_channel();
            middle--;
            if (middle != 0) state = S_FPNFR; else end_plate();
        endfunction
        function void labeled_done(logic [2:0] fl);
            emit(KIND_LABELED, 0, itm, held_id, held[0], held[1], held[2], held[3], fl);
            itm++; outer--;
            if (outer != 0) state = S_LID; else after_labeled();
        endfunction

        function void parse_field(logic [63:0] v);
            logic [31:0] w, n;
            w = v[31:0];
            case (state)
                S_MSGID:
                begin
                    held_id = {16'd0, w[15:0]}; state = S_NBYTES;
                end
                S_NBYTES:
                    if (held_id[15:0] != FRAME_MSG_ID)
                    begin
                        emit(KIND_UNKNOWN, 0, 0, {{16{held_id[15]}}, held_id[15:0]},
                             {16'd0, w[15:0]}, 0, 0, 0, 0);
                        state = S_DRAIN;
                    end
                    else
                    begin
                        held[0] = {16'd0, w[15:0]}; state = S_FRAMENO;
                    end
                S_FRAMENO:
                begin
                    emit(KIND_HEADER, 0, 0, w, held[0], 0, 0, 0, 0); state = S_NSETS;
                end
                S_NSETS:
                begin
                    outer = count_of(w); grp = 0;
                    if (outer != 0)
                    begin
                        itm = 0; state = S_NAME;
                    end
                    else state = S_NOTHER;
                end
                S_NAME:
                    if (w[7:0] == 0) state = S_NMARK;
                    else if (itm < NAME_LIMIT - 1)
                    begin
                        emit(KIND_NAME_CHAR, grp, itm, 0, {24'd0, w[7:0]}, 0, 0, 0, 0); itm++;
                    end
                    else if (itm == NAME_LIMIT - 1)
                    begin
                        emit(KIND_ERROR, 0, 0, ERR_NAME_LONG, 0, 0, 0, 0, 0); itm++;
                    end
                S_NMARK:
                begin
                    n = count_of(w);
                    emit(KIND_SET_START, grp, 0, n, 0, 0, 0, 0, 0);
                    inner = n; itm = 0;
                    if (n != 0) state = S_MX; else end_set();
                end
                S_MX: begin held[0] = w; state = S_MY; end
                S_MY: begin held[1] = w; state = S_MZ; end
                S_MZ:
                begin
                    emit(KIND_MARKER, grp, itm, 0, held[0], held[1], w, 0, 0);
                    itm++; inner--;
                    if (inner != 0) state = S_MX; else end_set();
                end
                S_NOTHER:
                begin
                    outer = count_of(w); itm = 0; in_skel = 0;
                    state = (outer != 0) ? S_OX : S_NBODIES;
                end
                S_OX: begin held[0] = w; state = S_OY; end
                S_OY: begin held[1] = w; state = S_OZ; end
                S_OZ:
                begin
                    emit(KIND_UNIDENT, 0, itm, 0, held[0], held[1], w, 0, 0);
                    itm++; outer--;
                    state = (outer != 0) ? S_OX : S_NBODIES;
                end
                S_NBODIES:
                begin
                    middle = count_of(w); grp = 0; itm = 0;
                    if (middle != 0) state = S_BID; else after_bodies();
                end
                S_BID: begin held_id = w; state = S_BX; end
                S_BX: begin held[0] = w; state = S_BY; end
                S_BY: begin held[1] = w; state = S_BZ; end
                S_BZ:
                begin
                    emit(KIND_POSE, grp, itm, held_id, held[0], held[1], w, 0, 0);
                    state = S_QX;
                end
                S_QX: begin held[0] = w; state = S_QY; end
                S_QY: begin held[1] = w; state = S_QZ; end
                S_QZ: begin held[2] = w; state = S_QW; end
                S_QW:
                begin
                    emit(KIND_ORIENT, grp, itm, held_id, held[0], held[1], held[2], w, 0);
                    state = S_BNMARK;
                end
                S_BNMARK:
                begin
                    n = count_of(w); mark_tot = n; inner = n; mark_idx = 0;
                    if (v20() && n > BODY_MARKER_SLOTS)
                        emit(KIND_ERROR, 0, 0, ERR_MARKER_OVF, 0, 0, 0, 0, 0);
                    if (n != 0) state = S_BMX; else after_positions();
                end
                S_BMX: begin held[0] = w; state = S_BMY; end
                S_BMY: begin held[1] = w; state = S_BMZ; end
                S_BMZ:
                begin
                    if (v20())
                    begin
                        if (mark_idx < BODY_MARKER_SLOTS)
                        begin
                            mpos[mark_idx][0] = held[0];
                            mpos[mark_idx][1] = held[1];
                            mpos[mark_idx][2] = w;
                        end
                    end
                    else
                        emit(KIND_BODY_MARK, grp, mark_idx[15:0], held_id, held[0], held[1], w,
                             0, 0);
                    mark_idx++; inner--;
                    if (inner != 0) state = S_BMX; else after_positions();
                end
                S_BMID:
                begin
                    inner--;
                    if (inner == 0)
                    begin
                        inner = mark_tot; mark_idx = 0; state = S_BMSIZE;
                    end
                end
                S_BMSIZE:
                begin
                    if (mark_idx < BODY_MARKER_SLOTS)
                        emit(KIND_BODY_MARK, grp, mark_idx[15:0], held_id, mpos[mark_idx][0],
                             mpos[mark_idx][1], mpos[mark_idx][2], w, 0);
                    else
                        emit(KIND_BODY_MARK, grp, mark_idx[15:0], held_id, 0, 0, 0, w, 0);
                    mark_idx++; inner--;
                    if (inner == 0) after_markers();
                end
                S_BERR:
                begin
                    held[3] = w;
                    if (v26()) state = S_BPARAMS; else end_body(0);
                end
                S_BPARAMS: end_body({2'b00, w[0]});
                S_NSKEL:
                begin
                    outer = count_of(w); grp = 0; in_skel = 1;
                    if (outer != 0) state = S_SKID; else after_skeletons();
                end
                S_SKID: begin held[0] = w; state = S_SKNB; end
                S_SKNB:
                begin
                    n = count_of(w);
                    emit(KIND_SKELETON, grp, 0, held[0], n, 0, 0, 0, 0);
                    middle = n; itm = 0;
                    if (n != 0) state = S_BID; else end_skeleton();
                end
                S_NLAB:
                begin
                    outer = count_of(w); itm = 0;
                    if (outer != 0) state = S_LID; else after_labeled();
                end
                S_LID: begin held_id = w; state = S_LX; end
                S_LX: begin held[0] = w; state = S_LY; end
                S_LY: begin held[1] = w; state = S_LZ; end
                S_LZ: begin held[2] = w; state = S_LSIZE; end
                S_LSIZE:
                begin
                    held[3] = w;
                    if (v26()) state = S_LPARAMS; else labeled_done(0);
                end
                S_LPARAMS: labeled_done(w[2:0]);
                S_NFP:
                begin
                    outer = count_of(w); state = (outer != 0) ? S_FPID : S_LAT;
                end
                S_FPID: state = S_FPNCH;
                S_FPNCH:
                begin
                    middle = count_of(w);
                    if (middle != 0) state = S_FPNFR; else end_plate();
                end
                S_FPNFR:
                begin
                    inner = count_of(w);
                    if (inner != 0) state = S_FPVAL; else end_channel();
                end
                S_FPVAL:
                begin
                    inner--;
                    if (inner == 0) end_channel();
                end
                S_LAT: begin held[0] = w; state = S_TC; end
                S_TC: begin held[1] = w; state = S_TCSUB; end
                S_TCSUB: begin held[2] = w; state = S_TS; end
                S_TS:
                begin
                    if (at_least(7)) emit(KIND_TIMESTAMP, 0, 0, 0, w, v[63:32], 0, 0, 3'd1);
                    else emit(KIND_TIMESTAMP, 0, 0, 0, w, 0, 0, 0, 0);
                    state = S_FPARAMS;
                end
                S_FPARAMS:
                begin
                    emit(KIND_FRAME_FLAG, 0, 0, 0, 0, 0, 0, 0, {1'b0, w[1:0]}); state = S_EOD;
                end
                S_EOD:
                begin
                    emit(KIND_TRAILER, 0, 0, w, held[0], held[1], held[2], 0, 0);
                    state = S_DRAIN;
                end
                default: state = S_DRAIN;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, bit pl);
            logic [63:0] v;
            step_out.delete();
            if (state == S_DRAIN)
            begin
                if (pl) emit(KIND_ERROR, 0, 0, ERR_TRAILING, 0, 0, 0, 0, 0);
            end
            else
            begin
                if (bcount != 16'hFFFF) bcount++;
                acc |= {56'd0, b} << (8 * (nin & 7));
                nin++;
                if (nin >= width_of())
                begin
                    v = acc; acc = 0; nin = 0;
                    parse_field(v);
                end
                if (pl && state != S_DRAIN)
                begin
                    while (step_out.size() > 1) void'(step_out.pop_back());
                    emit(KIND_ERROR, 0, 0, ERR_TRUNCATED, 0, 0, 0, 0, 0);
                end
            end
            foreach (step_out[k])
            begin
                step_out[k].consumed_bytes = bcount;
                step_out[k].last = pl && (k == step_out.size() - 1);
                pending.push_back(step_out[k]);
            end
            if (pl) restart();
        endfunction

        function void compare(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_record(record_t got);
            record_t e;
            if (pending.size() == 0)
            begin
                $error("record kind %0d arrived with none expected", got.record_kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            compare("record_kind", e.record_kind, got.record_kind);
            compare("group_index", e.group_index, got.group_index);
            compare("item_index", e.item_index, got.item_index);
            compare("ident", e.ident, got.ident);
            compare("word_x", e.word_x, got.word_x);
            compare("word_y", e.word_y, got.word_y);
            compare("word_z", e.word_z, got.word_z);
            compare("word_w", e.word_w, got.word_w);
            compare("flags", e.flags, got.flags);
            compare("consumed_bytes", e.consumed_bytes, got.consumed_bytes);
            compare("last", e.last, got.last);
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic cfg_index = CFG_MAJOR;
    logic [3:0] cfg_data = 0;
    mfp_byte_if pkt ();
    mfp_rec_if rec ();

    mocap_frame_packet_parser dut (
        .clk(clk), .rst_n(rst_n), .pkt(pkt.sink), .rec(rec.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    record_scoreboard sb = new();
    logic [7:0] packet_bytes[$];
    bit steady = 0;
    bit hold_for_drain = 0;
    longint cycles = 0;
    int random_bytes = 0;
    int stall_left = 0;
    logic [3:0] ver_major = 0, ver_minor = 0;

    initial pkt.valid = 0;
    initial pkt.data_byte = 0;
    initial pkt.packet_last = 0;
    initial rec.ready = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("mocap_frame_packet_parser: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && rec.valid && rec.ready)
            sb.check_record({rec.record_kind, rec.group_index, rec.item_index, rec.ident,
                             rec.word_x, rec.word_y, rec.word_z, rec.word_w, rec.flags,
                             rec.consumed_bytes, rec.last});

    always @(negedge clk)
    begin
        if (steady) rec.ready = 1;
        else if (stall_left > 0)
        begin
            rec.ready = 0;
            stall_left--;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            rec.ready = 0;
            stall_left = $urandom_range(0, 6);
        end
        else rec.ready = 1;
    end

    function bit ver_at(int unsigned mi);
        return (ver_major == 2 && ver_minor >= mi) || ver_major > 2;
    endfunction

    function void add(logic [63:0] v, int n);
        for (int i = 0; i < n; i++) packet_bytes.push_back(v[8 * i +: 8]);
    endfunction

    function logic [31:0] some_count(int hi);
        if ($urandom_range(0, 11) == 0) return $urandom | 32'h8000_0000;
        return $urandom_range(0, hi);
    endfunction

    function void add_body(int nmark);
        add($urandom, 4);
        for (int i = 0; i < 7; i++) add($urandom, 4);
        add(nmark, 4);
        for (int i = 0; i < nmark * 3; i++) add($urandom, 4);
        if (ver_major >= 2)
        begin
            for (int i = 0; i < nmark * 2; i++) add($urandom, 4);
            add($urandom, 4);
        end
        if (ver_at(6) || ver_major == 0) add($urandom, 2);
    endfunction

    function void add_bodies(logic [31:0] n);
        add(n, 4);
        if (!n[31])
            for (int b = 0; b < n; b++) add_body($urandom_range(0, 3));
    endfunction

    // Builds a frame and 0-3 extra bytes; nonzero name_len or body_marks widens a section.
    function void build_frame(int name_len, int body_marks);
        logic [31:0] n, m;
        packet_bytes.delete();
        add(FRAME_MSG_ID, 2);
        add($urandom, 2);
        add($urandom, 4);
        n = (name_len > 0) ? 32'd1 : some_count(2);
        add(n, 4);
        if (!n[31])
            for (int s = 0; s < n; s++)
            begin
                m = (name_len > 0) ? name_len : $urandom_range(0, 5);
                for (int c = 0; c < m; c++) add($urandom_range(1, 255), 1);
                add(0, 1);
                m = some_count(3);
                add(m, 4);
                if (!m[31])
                    for (int k = 0; k < m * 3; k++) add($urandom, 4);
            end
        n = some_count(2);
        add(n, 4);
        if (!n[31])
            for (int k = 0; k < n * 3; k++) add($urandom, 4);
        if (body_marks > 0)
        begin
            add(1, 4);
            add_body(body_marks);
        end
        else add_bodies(some_count(2));
        if ((ver_major == 2 && ver_minor > 0) || ver_major > 2)
        begin
            n = some_count(2);
            add(n, 4);
            if (!n[31])
                for (int s = 0; s < n; s++)
                begin
                    add($urandom, 4);
                    add_bodies(some_count(2));
                end
        end
        if (ver_at(3))
        begin
            n = some_count(2);
            add(n, 4);
            if (!n[31])
                for (int s = 0; s < n; s++)
                begin
                    for (int k = 0; k < 5; k++) add($urandom, 4);
                    if (ver_at(6) || ver_major == 0) add($urandom, 2);
                end
        end
        if (ver_at(9))
        begin
            n = some_count(1);
            add(n, 4);
            if (!n[31])
                for (int p = 0; p < n; p++)
                begin
                    add($urandom, 4);
                    m = some_count(2);
                    add(m, 4);
                    if (!m[31])
                        for (int c = 0; c < m; c++)
                        begin
                            logic [31:0] f;
                            f = some_count(2);
                            add(f, 4);
                            if (!f[31])
                                for (int k = 0; k < f; k++) add($urandom, 4);
                        end
                end
        end
        for (int k = 0; k < 3; k++) add($urandom, 4);
        add({$urandom, $urandom}, ver_at(7) ? 8 : 4);
        add($urandom, 2);
        add($urandom, 4);
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) add($urandom, 1);
    endfunction

    task automatic send_byte(logic [7:0] b, bit pl);
        int gap;
        if (!steady && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 7);
            pkt.valid = 0;
            repeat (gap) @(negedge clk);
        end
        pkt.valid = 1;
        pkt.data_byte = b;
        pkt.packet_last = pl;
        forever
        begin
            @(posedge clk);
            if (pkt.ready) break;
        end
        sb.note_byte(b, pl);
        @(negedge clk);
    endtask

    task automatic send_packet(bit counted);
        int n;
        n = packet_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            if (hold_for_drain && i == n / 2)
            begin
                pkt.valid = 0;
                hold_for_drain = 0;
                while (sb.pending.size() != 0) @(negedge clk);
            end
            send_byte(packet_bytes[i], i == n - 1);
            if (counted) random_bytes++;
        end
        pkt.valid = 0;
    endtask

    task automatic set_version(logic [3:0] ma, logic [3:0] mi);
        pkt.valid = 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
        cfg_we = 1;
        cfg_index = CFG_MAJOR;
        cfg_data = ma;
        @(negedge clk);
        cfg_index = CFG_MINOR;
        cfg_data = mi;
        @(negedge clk);
        cfg_we = 0;
        sb.major = ma;
        sb.minor = mi;
        ver_major = ma;
        ver_minor = mi;
    endtask

    task automatic random_packet(bit counted);
        int kind, cut;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            packet_bytes.delete();
            repeat ($urandom_range(1, 12)) add($urandom, 1);
        end
        else
        begin
            build_frame(0, 0);
            if (kind == 1)
            begin
                cut = $urandom_range(1, packet_bytes.size());
                while (packet_bytes.size() > cut) void'(packet_bytes.pop_back());
            end
        end
        send_packet(counted);
    endtask

    initial
    begin
        logic [3:0] versions[10][2];
        int v;
        versions = '{'{0, 0}, '{15, 15}, '{2, 0}, '{2, 1}, '{2, 3}, '{2, 6}, '{2, 7},
                     '{2, 9}, '{1, 5}, '{3, 0}};
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: one frame at reset version, then each special case.
        build_frame(0, 0);
        send_packet(0);
        set_version(2, 6);
        build_frame(NAME_LIMIT + 4, 0);
        send_packet(0);
        set_version(3, 0);
        build_frame(0, BODY_MARKER_SLOTS + 2);
        send_packet(0);
        packet_bytes.delete();
        add(16'hFFFF, 2);
        add(16'hFFFF, 2);
        add(32'hFFFF_FFFF, 4);
        send_packet(0);
        packet_bytes.delete();
        add(16'h0000, 2);
        add(16'h0000, 2);
        send_packet(0);
        packet_bytes.delete();
        add(FRAME_MSG_ID, 2);
        add(0, 2);
        add(0, 3);
        send_packet(0);
        set_version(15, 15);
        build_frame(0, 0);
        send_packet(0);

        hold_for_drain = 1;
        v = 0;
        while (random_bytes < 750)
        begin
            set_version(versions[v % 10][0], versions[v % 10][1]);
            if (random_bytes > 600) steady = 1;
            repeat (3) random_packet(1);
            v++;
        end

        pkt.valid = 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (sb.errors == 0)
            $display("mocap_frame_packet_parser: match");
        else
            $display("mocap_frame_packet_parser: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
hw/rtl/mfp_pkg.sv
hw/rtl/mfp_if.sv
hw/rtl/mfp_marker_mem.sv
hw/rtl/mfp_out_fifo.sv
hw/rtl/mfp_core.sv
hw/rtl/mocap_frame_packet_parser.sv
tb/mocap_frame_packet_parser_test.sv
